// ===== rtl/hwu_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Hebbian weight update block.
`timescale 1ns / 1ps
package hwu_pkg;

  localparam int DIM_DEFAULT = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam logic [5:0] SIG_LAST = 6'd32;
  localparam logic [4:0] TANH_LAST = 5'd16;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_APPLY  = 2'd1,
    OP_ENERGY = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GATE_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTROPY_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_KEEP      = 3'd4;

  // Result kinds.
  localparam logic KIND_APPLY  = 1'b0;
  localparam logic KIND_ENERGY = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         elem_index;
    logic signed [31:0] g_value;
    logic signed [31:0] r_value;
    logic signed [31:0] entropy;
    logic               final_elem;
  } req_t;

  typedef struct packed {
    logic               result_kind;
    logic [5:0]         out_index;
    logic signed [63:0] out_value;
    logic               run_end;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WR,
    S_EMA_G1, S_EMA_G2, S_EMA_G3, S_EMA_R2, S_EMA_R3,
    S_FIN,
    S_LR_MUL, S_LR_AX, S_LR_INT, S_LR_S, S_LR_RATE, S_LR_END,
    S_L_RD, S_L_P1, S_L_P2, S_L_H, S_L_RH, S_L_T, S_L_D, S_L_DM, S_L_W,
    S_A_RD, S_A_MUL, S_A_ACC, S_A_OUT,
    S_E_RD, S_E_MUL, S_E_ACC, S_E_OUT
  } state_t;

  // Round a Q16.16 product half up: floor(x / 2^16 + 1/2).
  function automatic logic signed [PROD_W-1:0] rnd16(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] t;
    t = x + PROD_W'(32768);
    return t >>> 16;
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sd2147483647);
    lo = -PROD_W'(64'sd2147483648);
    if (x > hi) return 32'sh7FFFFFFF;
    if (x < lo) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Sigmoid samples, step 0.25 on [0, 8].
  function automatic logic [16:0] sig_tab(input logic [5:0] i);
    logic [16:0] v;
    unique case (i)
      6'd0: v = 17'd32768;  6'd1: v = 17'd36843;  6'd2: v = 17'd40793;
      6'd3: v = 17'd44511;  6'd4: v = 17'd47910;  6'd5: v = 17'd50941;
      6'd6: v = 17'd53580;  6'd7: v = 17'd55833;  6'd8: v = 17'd57723;
      6'd9: v = 17'd59287;  6'd10: v = 17'd60564; 6'd11: v = 17'd61598;
      6'd12: v = 17'd62427; 6'd13: v = 17'd63089; 6'd14: v = 17'd63614;
      6'd15: v = 17'd64026; 6'd16: v = 17'd64357; 6'd17: v = 17'd64614;
      6'd18: v = 17'd64815; 6'd19: v = 17'd64973; 6'd20: v = 17'd65097;
      6'd21: v = 17'd65193; 6'd22: v = 17'd65269; 6'd23: v = 17'd65328;
      6'd24: v = 17'd65373; 6'd25: v = 17'd65409; 6'd26: v = 17'd65437;
      6'd27: v = 17'd65459; 6'd28: v = 17'd65476; 6'd29: v = 17'd65489;
      6'd30: v = 17'd65500; 6'd31: v = 17'd65508; 6'd32: v = 17'd65514;
      default: v = 17'd65514;
    endcase
    return v;
  endfunction

  // Tanh samples, step 0.25 on [0, 4].
  function automatic logic [16:0] tanh_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0: v = 17'd0;      5'd1: v = 17'd16051;  5'd2: v = 17'd30285;
      5'd3: v = 17'd41625;  5'd4: v = 17'd49911;  5'd5: v = 17'd55593;
      5'd6: v = 17'd59320;  5'd7: v = 17'd61694;  5'd8: v = 17'd63178;
      5'd9: v = 17'd64096;  5'd10: v = 17'd64659; 5'd11: v = 17'd65002;
      5'd12: v = 17'd65212; 5'd13: v = 17'd65339; 5'd14: v = 17'd65417;
      5'd15: v = 17'd65463; 5'd16: v = 17'd65492;
      default: v = 17'd65492;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/hwu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hwu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hwu_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module hwu_mul (
  input  logic                                 clk,
  input  logic signed [hwu_pkg::MUL_W-1:0]     a,
  input  logic signed [hwu_pkg::MUL_W-1:0]     b,
  output logic signed [hwu_pkg::PROD_W-1:0]    p
);

  // Every datapath product of the block goes through this one register.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/hebbian_weight_update.sv =====
// Top level of the covariance Hebbian weight update block.
//
// Usage: requests arrive on req/req_valid/req_stall and results leave on
// rsp/rsp_valid/rsp_stall; a transfer happens when valid is high and stall
// is low. Configuration registers are written through cfg_we/cfg_index/
// cfg_data while the block is idle.
// One request is worked on at a time by a sequencer around one shared
// multiplier, so req_stall stays high until the request is finished.
// A plain element with a valid index stores its values, and an update
// element also moves the means. A final update element then computes the
// gated rate and updates every weight. A final apply element emits DIM
// results, one per row. An energy query emits one result. After reset a
// clearing pass zeroes the weights and the means; no request is taken
// during that pass.
// Results sit in an output register; while rsp_stall is high the block
// holds the pending result and waits before loading the next one. A new
// request is taken while the last result still waits.
`timescale 1ns / 1ps
module hebbian_weight_update #(
  parameter int DIM = hwu_pkg::DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  hwu_pkg::req_t                      req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output hwu_pkg::rsp_t                      rsp,
  input  logic                               cfg_we,
  input  logic [hwu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hwu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WI = $clog2(DIM);
  localparam int NW = DIM * DIM;
  localparam int WA = $clog2(NW);
  localparam int PW = hwu_pkg::PROD_W;
  localparam int MW = hwu_pkg::MUL_W;

  // Configuration registers.
  logic signed [31:0] gate_gain;
  logic signed [31:0] entropy_center;
  logic [30:0]        base_rate;
  logic [30:0]        decay_rate;
  logic [16:0]        mean_keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_gain      <= 32'sd65536;
      entropy_center <= 32'sd0;
      base_rate      <= 31'd655;
      decay_rate     <= 31'd66;
      mean_keep      <= 17'd58982;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hwu_pkg::REG_GATE_GAIN:      gate_gain <= cfg_data;
        hwu_pkg::REG_ENTROPY_CENTER: entropy_center <= cfg_data;
        hwu_pkg::REG_BASE_RATE:      base_rate <= cfg_data[30:0];
        hwu_pkg::REG_DECAY_RATE:     decay_rate <= cfg_data[30:0];
        hwu_pkg::REG_MEAN_KEEP: begin
          mean_keep <= (cfg_data[16:0] > hwu_pkg::ONE_Q16) ? hwu_pkg::ONE_Q16
                                                          : cfg_data[16:0];
        end
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers.
  hwu_pkg::state_t state, state_next;
  hwu_pkg::req_t   itm;
  logic [WI-1:0]   i_cnt;
  logic [WI-1:0]   j_cnt;
  logic [WA-1:0]   k_cnt;
  logic signed [PW-1:0] acc;
  logic signed [31:0]   wv;
  logic signed [31:0]   hv;
  logic [16:0]          tv;
  logic [16:0]          sv;
  logic [30:0]          rate;
  logic [5:0]           sidx;
  logic [13:0]          sfrac;
  logic                 ax_nz;
  logic [63:0]          esum;

  // Memories.
  logic                 w_we, mean_we_g, mean_we_r, buf_we;
  logic [WA-1:0]        w_waddr, w_raddr;
  logic [31:0]          w_wdata, w_rd;
  logic [WI-1:0]        mean_waddr, mg_raddr, mr_raddr;
  logic [31:0]          mg_wdata, mr_wdata, mg_rd, mr_rd;
  logic [31:0]          gb_rd, rb_rd;
  logic [WI-1:0]        idx_lo;

  // Shared multiplier.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  hwu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  hwu_ram #(.WIDTH(32), .DEPTH(NW)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rd));
  hwu_ram #(.WIDTH(32), .DEPTH(DIM)) u_mg_ram (
    .clk(clk), .we(mean_we_g), .waddr(mean_waddr), .wdata(mg_wdata),
    .raddr(mg_raddr), .rdata(mg_rd));
  hwu_ram #(.WIDTH(32), .DEPTH(DIM)) u_mr_ram (
    .clk(clk), .we(mean_we_r), .waddr(mean_waddr), .wdata(mr_wdata),
    .raddr(mr_raddr), .rdata(mr_rd));
  hwu_ram #(.WIDTH(32), .DEPTH(DIM)) u_gb_ram (
    .clk(clk), .we(buf_we), .waddr(idx_lo), .wdata(itm.g_value),
    .raddr(i_cnt), .rdata(gb_rd));
  hwu_ram #(.WIDTH(32), .DEPTH(DIM)) u_rb_ram (
    .clk(clk), .we(buf_we), .waddr(idx_lo), .wdata(itm.r_value),
    .raddr(j_cnt), .rdata(rb_rd));

  // Item decode.
  logic idx_ok;
  logic ema_phase;
  logic i_last, j_last, k_last;
  assign idx_lo    = itm.elem_index[WI-1:0];
  assign idx_ok    = {1'b0, itm.elem_index} < 7'(DIM);
  assign i_last    = i_cnt == WI'(DIM - 1);
  assign j_last    = j_cnt == WI'(DIM - 1);
  assign k_last    = k_cnt == WA'(NW - 1);
  assign ema_phase = (state == hwu_pkg::S_WR) || (state == hwu_pkg::S_EMA_G1) ||
                     (state == hwu_pkg::S_EMA_G2) || (state == hwu_pkg::S_EMA_G3) ||
                     (state == hwu_pkg::S_EMA_R2) || (state == hwu_pkg::S_EMA_R3);

  // Read addresses follow the phase of the sequencer.
  logic [WA-1:0] ij_addr;
  assign ij_addr  = WA'(i_cnt) * WA'(DIM) + WA'(j_cnt);
  assign w_raddr  = ((state == hwu_pkg::S_E_RD) || (state == hwu_pkg::S_E_MUL))
                    ? k_cnt : ij_addr;
  assign mg_raddr = ema_phase ? idx_lo : i_cnt;
  assign mr_raddr = ema_phase ? idx_lo : j_cnt;

  // Learning-rate gate operands.
  logic signed [32:0] ent_d;
  logic [32:0]        ent_md;
  logic [31:0]        gain_m;
  logic               gate_neg;
  assign ent_d    = {itm.entropy[31], itm.entropy} - {entropy_center[31], entropy_center};
  assign ent_md   = ent_d[32] ? 33'(-ent_d) : 33'(ent_d);
  assign gain_m   = gate_gain[31] ? 32'(-gate_gain) : 32'(gate_gain);
  assign gate_neg = ent_d[32] ^ gate_gain[31];

  // Sigmoid segment slope.
  logic [16:0] sig_slope;
  assign sig_slope = (sidx == hwu_pkg::SIG_LAST) ? 17'd0
                     : hwu_pkg::sig_tab(sidx + 6'd1) - hwu_pkg::sig_tab(sidx);

  // Tanh segment of the current weight magnitude.
  logic [31:0] aw;
  logic [4:0]  tidx;
  logic [13:0] tfrac;
  logic [16:0] tanh_slope;
  assign aw    = wv[31] ? 32'(-wv) : 32'(wv);
  assign tidx  = (|aw[31:18]) ? hwu_pkg::TANH_LAST : {1'b0, aw[17:14]};
  assign tfrac = (|aw[31:18]) ? 14'd0 : aw[13:0];
  assign tanh_slope = (tidx == hwu_pkg::TANH_LAST) ? 17'd0
                      : hwu_pkg::tanh_tab(tidx + 5'd1) - hwu_pkg::tanh_tab(tidx);

  // Interpolation correction from the product register.
  logic [16:0] interp_add;
  assign interp_add = 17'((prod + PW'(8192)) >>> 14);

  // Moving-mean result and the retain complement.
  logic [17:0]          keep_c;
  logic signed [31:0]   ema_val;
  assign keep_c  = 18'(hwu_pkg::ONE_Q16) - 18'(mean_keep);
  assign ema_val = hwu_pkg::sat32(hwu_pkg::rnd16(acc + prod));

  // Weight update pieces.
  logic signed [PW-1:0] rprod;
  logic signed [PW-1:0] nw;
  assign rprod = hwu_pkg::rnd16(prod);
  always_comb begin
    nw = acc;
    if (wv > 32'sd0) begin
      nw = acc - rprod;
    end else if (wv < 32'sd0) begin
      nw = acc + rprod;
    end
  end

  // Energy running sum with saturation.
  logic [63:0] esum_add;
  assign esum_add = esum + prod[63:0];

  // Output register control.
  logic rsp_free;
  logic rsp_load;
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Next state, multiplier operands and memory writes.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    w_we       = 1'b0;
    w_waddr    = ij_addr;
    w_wdata    = hwu_pkg::sat32(nw);
    mean_we_g  = 1'b0;
    mean_we_r  = 1'b0;
    mean_waddr = idx_lo;
    mg_wdata   = ema_val;
    mr_wdata   = ema_val;
    buf_we     = 1'b0;
    rsp_load   = 1'b0;
    req_stall  = 1'b1;
    unique case (state)
      hwu_pkg::S_CLEAR: begin
        w_we       = 1'b1;
        w_waddr    = k_cnt;
        w_wdata    = '0;
        mean_waddr = k_cnt[WI-1:0];
        mean_we_g  = k_cnt < WA'(DIM);
        mean_we_r  = k_cnt < WA'(DIM);
        mg_wdata   = '0;
        mr_wdata   = '0;
        if (k_last) state_next = hwu_pkg::S_IDLE;
      end
      hwu_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          unique case (req.opcode)
            hwu_pkg::OP_UPDATE, hwu_pkg::OP_APPLY: state_next = hwu_pkg::S_WR;
            hwu_pkg::OP_ENERGY:                    state_next = hwu_pkg::S_E_RD;
            default:                               state_next = hwu_pkg::S_IDLE;
          endcase
        end
      end
      hwu_pkg::S_WR: begin
        buf_we = idx_ok;
        state_next = (idx_ok && itm.opcode == hwu_pkg::OP_UPDATE)
                     ? hwu_pkg::S_EMA_G1 : hwu_pkg::S_FIN;
      end
      hwu_pkg::S_EMA_G1: begin
        mul_a = MW'(mean_keep);
        mul_b = MW'(signed'(mg_rd));
        state_next = hwu_pkg::S_EMA_G2;
      end
      hwu_pkg::S_EMA_G2: begin
        mul_a = MW'(keep_c);
        mul_b = MW'(itm.g_value);
        state_next = hwu_pkg::S_EMA_G3;
      end
      hwu_pkg::S_EMA_G3: begin
        mean_we_g = 1'b1;
        mul_a = MW'(mean_keep);
        mul_b = MW'(signed'(mr_rd));
        state_next = hwu_pkg::S_EMA_R2;
      end
      hwu_pkg::S_EMA_R2: begin
        mul_a = MW'(keep_c);
        mul_b = MW'(itm.r_value);
        state_next = hwu_pkg::S_EMA_R3;
      end
      hwu_pkg::S_EMA_R3: begin
        mean_we_r = 1'b1;
        state_next = hwu_pkg::S_FIN;
      end
      hwu_pkg::S_FIN: begin
        if (!itm.final_elem) begin
          state_next = hwu_pkg::S_IDLE;
        end else if (itm.opcode == hwu_pkg::OP_UPDATE) begin
          state_next = hwu_pkg::S_LR_MUL;
        end else begin
          state_next = hwu_pkg::S_A_RD;
        end
      end
      hwu_pkg::S_LR_MUL: begin
        mul_a = MW'(ent_md);
        mul_b = MW'(gain_m);
        state_next = hwu_pkg::S_LR_AX;
      end
      hwu_pkg::S_LR_AX: state_next = hwu_pkg::S_LR_INT;
      hwu_pkg::S_LR_INT: begin
        mul_a = MW'(sig_slope);
        mul_b = MW'(sfrac);
        state_next = hwu_pkg::S_LR_S;
      end
      hwu_pkg::S_LR_S: state_next = hwu_pkg::S_LR_RATE;
      hwu_pkg::S_LR_RATE: begin
        mul_a = MW'(base_rate);
        mul_b = MW'(sv);
        state_next = hwu_pkg::S_LR_END;
      end
      hwu_pkg::S_LR_END: state_next = hwu_pkg::S_L_RD;
      hwu_pkg::S_L_RD: state_next = hwu_pkg::S_L_P1;
      hwu_pkg::S_L_P1: begin
        mul_a = MW'(signed'(gb_rd));
        mul_b = MW'(signed'(rb_rd));
        state_next = hwu_pkg::S_L_P2;
      end
      hwu_pkg::S_L_P2: begin
        mul_a = MW'(signed'(mg_rd));
        mul_b = MW'(signed'(mr_rd));
        state_next = hwu_pkg::S_L_H;
      end
      hwu_pkg::S_L_H: state_next = hwu_pkg::S_L_RH;
      hwu_pkg::S_L_RH: begin
        mul_a = MW'(rate);
        mul_b = MW'(hv);
        state_next = hwu_pkg::S_L_T;
      end
      hwu_pkg::S_L_T: begin
        mul_a = MW'(tanh_slope);
        mul_b = MW'(tfrac);
        state_next = hwu_pkg::S_L_D;
      end
      hwu_pkg::S_L_D: state_next = hwu_pkg::S_L_DM;
      hwu_pkg::S_L_DM: begin
        mul_a = MW'(decay_rate);
        mul_b = MW'(tv);
        state_next = hwu_pkg::S_L_W;
      end
      hwu_pkg::S_L_W: begin
        w_we = 1'b1;
        state_next = (i_last && j_last) ? hwu_pkg::S_IDLE : hwu_pkg::S_L_RD;
      end
      hwu_pkg::S_A_RD: state_next = hwu_pkg::S_A_MUL;
      hwu_pkg::S_A_MUL: begin
        mul_a = MW'(signed'(w_rd));
        mul_b = MW'(signed'(rb_rd));
        state_next = hwu_pkg::S_A_ACC;
      end
      hwu_pkg::S_A_ACC: state_next = j_last ? hwu_pkg::S_A_OUT : hwu_pkg::S_A_RD;
      hwu_pkg::S_A_OUT: begin
        if (rsp_free) begin
          rsp_load = 1'b1;
          state_next = i_last ? hwu_pkg::S_IDLE : hwu_pkg::S_A_RD;
        end
      end
      hwu_pkg::S_E_RD: state_next = hwu_pkg::S_E_MUL;
      hwu_pkg::S_E_MUL: begin
        mul_a = MW'(signed'(w_rd));
        mul_b = MW'(signed'(w_rd));
        state_next = hwu_pkg::S_E_ACC;
      end
      hwu_pkg::S_E_ACC: state_next = k_last ? hwu_pkg::S_E_OUT : hwu_pkg::S_E_RD;
      hwu_pkg::S_E_OUT: begin
        if (rsp_free) begin
          rsp_load = 1'b1;
          state_next = hwu_pkg::S_IDLE;
        end
      end
      default: state_next = hwu_pkg::S_IDLE;
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwu_pkg::S_CLEAR;
      k_cnt <= '0;
      i_cnt <= '0;
      j_cnt <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        hwu_pkg::S_CLEAR: k_cnt <= k_cnt + WA'(1);
        hwu_pkg::S_IDLE: begin
          k_cnt <= '0;
          i_cnt <= '0;
          j_cnt <= '0;
        end
        hwu_pkg::S_L_W: begin
          j_cnt <= j_last ? '0 : j_cnt + WI'(1);
          if (j_last) i_cnt <= i_cnt + WI'(1);
        end
        hwu_pkg::S_A_ACC: begin
          if (!j_last) j_cnt <= j_cnt + WI'(1);
        end
        hwu_pkg::S_A_OUT: begin
          if (rsp_free) begin
            j_cnt <= '0;
            i_cnt <= i_cnt + WI'(1);
          end
        end
        hwu_pkg::S_E_ACC: k_cnt <= k_cnt + WA'(1);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      hwu_pkg::S_IDLE: begin
        if (req_valid) itm <= req;
        esum <= '0;
      end
      hwu_pkg::S_EMA_G2, hwu_pkg::S_EMA_R2: acc <= prod;
      hwu_pkg::S_LR_AX: begin
        ax_nz <= |prod[64:16];
        if (|prod[64:35]) begin
          sidx  <= hwu_pkg::SIG_LAST;
          sfrac <= '0;
        end else begin
          sidx  <= {1'b0, prod[34:30]};
          sfrac <= prod[29:16];
        end
      end
      hwu_pkg::S_LR_S: begin
        sv <= (gate_neg && ax_nz)
              ? hwu_pkg::ONE_Q16 - (hwu_pkg::sig_tab(sidx) + interp_add)
              : hwu_pkg::sig_tab(sidx) + interp_add;
      end
      hwu_pkg::S_LR_END: rate <= rprod[30:0];
      hwu_pkg::S_L_P1: wv <= w_rd;
      hwu_pkg::S_L_P2: acc <= rprod;
      hwu_pkg::S_L_H: hv <= hwu_pkg::sat32(acc - rprod);
      hwu_pkg::S_L_T: acc <= PW'(wv) + rprod;
      hwu_pkg::S_L_D: tv <= hwu_pkg::tanh_tab(tidx) + interp_add;
      hwu_pkg::S_A_MUL: begin
        if (j_cnt == '0) acc <= PW'(signed'(gb_rd));
      end
      hwu_pkg::S_A_ACC: acc <= acc + rprod;
      hwu_pkg::S_E_ACC: esum <= esum_add[63] ? 64'h7FFF_FFFF_FFFF_FFFF : esum_add;
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (state == hwu_pkg::S_E_OUT) begin
        rsp.result_kind <= hwu_pkg::KIND_ENERGY;
        rsp.out_index   <= '0;
        rsp.out_value   <= esum;
        rsp.run_end     <= 1'b1;
      end else begin
        rsp.result_kind <= hwu_pkg::KIND_APPLY;
        rsp.out_index   <= 6'(i_cnt);
        rsp.out_value   <= 64'(hwu_pkg::sat32(acc));
        rsp.run_end     <= i_last;
      end
    end
  end

  // Checks on the sequencer and the result path.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || !rsp_stall))
    else $error("result loaded over a stalled result");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == hwu_pkg::S_CLEAR) |-> (!rsp_valid && req_stall))
    else $error("activity during the clearing pass");

  a_energy_shape: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == hwu_pkg::KIND_ENERGY) |->
      (rsp.run_end && rsp.out_index == 6'd0))
    else $error("malformed energy result");

  a_keep_range: assert property (@(posedge clk) disable iff (rst)
    mean_keep <= hwu_pkg::ONE_Q16)
    else $error("mean retain factor above one");

  a_weight_write: assert property (@(posedge clk) disable iff (rst)
    w_we |-> (state == hwu_pkg::S_L_W || state == hwu_pkg::S_CLEAR))
    else $error("weight written outside learning or clearing");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Hebbian weight update block.
`timescale 1ns / 1ps
module tb_top;

  localparam int DIM = 16;
  localparam int RANDOM_ITEMS = 90;
  localparam int SETTLE_CYCLES = 9 * DIM * DIM + 200;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  hwu_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  hwu_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [hwu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hwu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  hebbian_weight_update #(.DIM(DIM)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block state and its configuration.
  int sig_pts[33] = '{32768, 36843, 40793, 44511, 47910, 50941, 53580, 55833, 57723,
                      59287, 60564, 61598, 62427, 63089, 63614, 64026, 64357, 64614,
                      64815, 64973, 65097, 65193, 65269, 65328, 65373, 65409, 65437,
                      65459, 65476, 65489, 65500, 65508, 65514};
  int tanh_pts[17] = '{0, 16051, 30285, 41625, 49911, 55593, 59320, 61694, 63178,
                       64096, 64659, 65002, 65212, 65339, 65417, 65463, 65492};
  int w_mat[DIM*DIM];
  int mean_g[DIM];
  int mean_r[DIM];
  int g_buf[DIM];
  int r_buf[DIM];
  longint gain_cfg, center_cfg, base_cfg, decay_cfg, keep_cfg;

  hwu_pkg::rsp_t expected_rsp[$];
  int errors = 0;
  int items_sent = 0;
  longint cycles = 0;
  logic calm = 1'b0;
  logic rsp_hold = 1'b0;
  int rsp_wait = 0;

  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Piecewise-linear table lookup with 0.25 steps, rounded interpolation.
  function automatic longint table_lerp(bit use_tanh, logic [63:0] ax);
    logic [63:0] i;
    longint lo, hi, last, frac;
    last = use_tanh ? 16 : 32;
    i = ax >> 14;
    if (i >= last) return use_tanh ? tanh_pts[last] : sig_pts[last];
    lo = use_tanh ? tanh_pts[i] : sig_pts[i];
    hi = use_tanh ? tanh_pts[i+1] : sig_pts[i+1];
    frac = longint'(ax & 64'h3FFF);
    return lo + (((hi - lo) * frac + 8192) >> 14);
  endfunction

  // Entropy-gated learning rate: base_rate * sigmoid(gain * (entropy - center)).
  function automatic longint gated_rate(longint ent);
    longint d, s;
    logic [63:0] md, mgn, ax;
    bit neg;
    d = ent - center_cfg;
    md = (d < 0) ? -d : d;
    mgn = (gain_cfg < 0) ? -gain_cfg : gain_cfg;
    ax = (md * mgn) >> 16;
    neg = (d < 0) != (gain_cfg < 0);
    s = table_lerp(1'b0, ax);
    if (neg && ax != 0) s = 65536 - s;
    return round_q16(base_cfg * s);
  endfunction

  // Covariance Hebbian step with tanh-shaped decay over every weight.
  function automatic void hebbian_learn(longint ent);
    longint rate, w, h, nw, dec;
    logic [63:0] aw;
    rate = gated_rate(ent);
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        w = w_mat[i*DIM+j];
        h = clip32(round_q16(longint'(g_buf[i]) * r_buf[j]) -
                   round_q16(longint'(mean_g[i]) * mean_r[j]));
        nw = w + round_q16(rate * h);
        if (w != 0) begin
          aw = (w < 0) ? -w : w;
          dec = round_q16(decay_cfg * table_lerp(1'b1, aw));
          nw = (w > 0) ? nw - dec : nw + dec;
        end
        w_mat[i*DIM+j] = int'(clip32(nw));
      end
    end
  endfunction

  function automatic int ema_step(int m, int x);
    return int'(clip32(round_q16(keep_cfg * m + (65536 - keep_cfg) * x)));
  endfunction

  // Work out the results that one accepted request causes.
  function automatic void predict_request(hwu_pkg::req_t r);
    int idx;
    longint acc, sq;
    logic [63:0] e;
    hwu_pkg::rsp_t x;
    idx = r.elem_index;
    if (r.opcode == hwu_pkg::OP_ENERGY) begin
      e = '0;
      for (int i = 0; i < DIM*DIM; i++) begin
        sq = longint'(w_mat[i]) * w_mat[i];
        e = (e + sq > 64'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : e + sq;
      end
      x.result_kind = hwu_pkg::KIND_ENERGY;
      x.out_index = '0;
      x.out_value = e;
      x.run_end = 1'b1;
      expected_rsp.push_back(x);
      return;
    end
    if (r.opcode == hwu_pkg::OP_NONE) return;
    if (idx < DIM) begin
      g_buf[idx] = r.g_value;
      r_buf[idx] = r.r_value;
      if (r.opcode == hwu_pkg::OP_UPDATE) begin
        mean_g[idx] = ema_step(mean_g[idx], r.g_value);
        mean_r[idx] = ema_step(mean_r[idx], r.r_value);
      end
    end
    if (!r.final_elem) return;
    if (r.opcode == hwu_pkg::OP_UPDATE) begin
      hebbian_learn(longint'(r.entropy));
      return;
    end
    for (int i = 0; i < DIM; i++) begin
      acc = g_buf[i];
      for (int j = 0; j < DIM; j++)
        acc += round_q16(longint'(w_mat[i*DIM+j]) * r_buf[j]);
      x.result_kind = hwu_pkg::KIND_APPLY;
      x.out_index = 6'(i);
      x.out_value = 64'(clip32(acc));
      x.run_end = (i == DIM - 1);
      expected_rsp.push_back(x);
    end
  endfunction

  // Send one request after a random gap and record what it should cause.
  task automatic send_req(hwu_pkg::req_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_request(r);
    items_sent++;
  endtask

  function automatic hwu_pkg::req_t make_req(hwu_pkg::opcode_t op, int idx, int g, int rv,
                                             int ent, bit fin);
    hwu_pkg::req_t r;
    r.opcode = op;
    r.elem_index = 6'(idx);
    r.g_value = g;
    r.r_value = rv;
    r.entropy = ent;
    r.final_elem = fin;
    return r;
  endfunction

  // Q16.16 values: full range, a few units, the extremes and zero.
  function automatic int rand_q();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
      4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 0;
    endcase
  endfunction

  function automatic int rand_entropy();
    return $urandom_range(0, 2) == 0 ? int'($urandom) :
           int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  task automatic send_run(hwu_pkg::opcode_t op, int len);
    for (int k = 0; k < len; k++)
      send_req(make_req(op, $urandom_range(0, DIM - 1), rand_q(), rand_q(),
                        rand_entropy(), k == len - 1));
  endtask

  // Wait until the block has nothing pending, including a silent learn pass.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back and mirror them in the shadow copy.
  task automatic load_config(int gg, int ec, int br, int dr, int mk);
    int vals[5];
    vals = '{gg, ec, br, dr, mk};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= hwu_pkg::CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    gain_cfg = longint'(gg);
    center_cfg = longint'(ec);
    base_cfg = longint'(br) & 64'h7FFFFFFF;
    decay_cfg = longint'(dr) & 64'h7FFFFFFF;
    keep_cfg = longint'(mk) & 64'h1FFFF;
    if (keep_cfg > 65536) keep_cfg = 65536;
  endtask

  // Extremes of the fields, every opcode and the special cases.
  task automatic test_directed();
    for (int i = 0; i < DIM; i++)
      send_req(make_req(hwu_pkg::OP_UPDATE, i,
                        i == 0 ? 32'h7FFFFFFF : i == 1 ? 32'h80000000 : rand_q(),
                        i == 0 ? 32'h80000000 : i == 1 ? 32'h7FFFFFFF : rand_q(),
                        32'h7FFFFFFF, i == DIM - 1));
    send_req(make_req(hwu_pkg::OP_APPLY, 3, 32'h00010000, 32'hFFFF0000, 0, 1'b1));
    send_req(make_req(hwu_pkg::OP_ENERGY, 0, 0, 0, 0, 1'b0));
    send_req(make_req(hwu_pkg::OP_NONE, 5, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      1'b1));
    send_req(make_req(hwu_pkg::OP_UPDATE, 63, 32'h12345678, 32'h87654321, 32'h80000000,
                      1'b1));
    send_req(make_req(hwu_pkg::OP_APPLY, 40, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1'b1));
    send_req(make_req(hwu_pkg::OP_ENERGY, 63, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      1'b1));
  endtask

  // Several register settings, the extremes among them.
  task automatic test_config_sweep();
    int settings[5][5];
    settings = '{'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 65536},
                 '{32'h80000000, 32'h7FFFFFFF, 0, 0, 0},
                 '{0, 0, 655, 66, 32'h1FFFF},
                 '{32'h00040000, 32'h00020000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32768},
                 '{65536, 0, 655, 66, 58982}};
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      load_config(settings[p][0], settings[p][1], settings[p][2],
                  settings[p][3], settings[p][4]);
      send_run(hwu_pkg::OP_UPDATE, $urandom_range(4, DIM));
      send_run(hwu_pkg::OP_APPLY, $urandom_range(1, 4));
      send_run(hwu_pkg::OP_UPDATE, $urandom_range(1, DIM));
      send_req(make_req(hwu_pkg::OP_ENERGY, 0, 0, 0, 0, 1'b1));
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    fork
      begin
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (4000) @(posedge clk);
        rsp_hold <= 1'b0;
      end
    join_none
    send_req(make_req(hwu_pkg::OP_ENERGY, 0, 0, 0, 0, 1'b0));
    send_run(hwu_pkg::OP_APPLY, 3);
    send_req(make_req(hwu_pkg::OP_ENERGY, 0, 0, 0, 0, 1'b0));
    send_run(hwu_pkg::OP_APPLY, 2);
  endtask

  // Sender pauses until every expected result has come, then resumes at once.
  task automatic test_drain_pause();
    send_run(hwu_pkg::OP_APPLY, 2);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    calm <= 1'b1;
    send_run(hwu_pkg::OP_UPDATE, DIM);
    send_run(hwu_pkg::OP_APPLY, 4);
    calm <= 1'b0;
  endtask

  // Mostly well-formed runs with random content, some noise.
  task automatic test_random();
    int start, pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) send_run(hwu_pkg::OP_UPDATE, $urandom_range(1, DIM));
      else if (pick < 16) send_run(hwu_pkg::OP_APPLY, $urandom_range(1, 6));
      else if (pick == 16) send_req(make_req(hwu_pkg::OP_ENERGY, $urandom_range(0, 63),
                                             rand_q(), rand_q(), rand_q(),
                                             $urandom_range(0, 1)));
      else if (pick == 17) send_req(make_req(hwu_pkg::OP_NONE, $urandom_range(0, 63),
                                             rand_q(), rand_q(), rand_q(),
                                             $urandom_range(0, 1)));
      else if (pick == 18) calm <= ~calm;
      else send_req(make_req($urandom_range(0, 1) ? hwu_pkg::OP_APPLY : hwu_pkg::OP_UPDATE,
                             $urandom_range(DIM, 63), rand_q(), rand_q(),
                             rand_entropy(), $urandom_range(0, 1)));
    end
    calm <= 1'b0;
  endtask

  // Result stall: a random wait per result, or a long hold when asked.
  always @(posedge clk) begin
    logic stall_next;
    if (rsp_valid && !rsp_stall) rsp_wait = calm ? 0 : $urandom_range(0, 6);
    stall_next = rsp_hold;
    if (!rsp_hold && rsp_wait > 0) begin
      stall_next = 1'b1;
      rsp_wait--;
    end
    rsp_stall <= rst ? 1'b0 : stall_next;
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    hwu_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d index=%0d value=%0d", $time,
                 rsp.result_kind, rsp.out_index, rsp.out_value);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.result_kind !== want.result_kind) begin
          errors++;
          $display("%0t: result_kind expected %0d got %0d", $time,
                   want.result_kind, rsp.result_kind);
        end
        if (rsp.out_index !== want.out_index) begin
          errors++;
          $display("%0t: out_index expected %0d got %0d", $time,
                   want.out_index, rsp.out_index);
        end
        if (rsp.out_value !== want.out_value) begin
          errors++;
          $display("%0t: out_value expected %0d got %0d", $time,
                   want.out_value, rsp.out_value);
        end
        if (rsp.run_end !== want.run_end) begin
          errors++;
          $display("%0t: run_end expected %0d got %0d", $time,
                   want.run_end, rsp.run_end);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DIM*DIM; i++) w_mat[i] = 0;
    for (int i = 0; i < DIM; i++) begin
      mean_g[i] = 0;
      mean_r[i] = 0;
      g_buf[i] = 0;
      r_buf[i] = 0;
    end
    gain_cfg = 65536;
    center_cfg = 0;
    base_cfg = 655;
    decay_cfg = 66;
    keep_cfg = 58982;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Let the clearing pass after reset finish.
    repeat (DIM * DIM + 20) @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_drain_pause();
    wait_idle();
    load_config(65536, 0, 32'h00008000, 655, 58982);
    test_random();
    wait_idle();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
